[hw/rtl/source_token_scanner_top_defines.svh]
// ----------------------------------------------------------------------------
// Source token scanner: shared assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication
`define STK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/stk_pkg.sv]
// ----------------------------------------------------------------------------
// Source token scanner package
// Widths, token kinds, character tables and shared types.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int OFFSET_WIDTH = 24;
  localparam int LENGTH_WIDTH = 16;
  localparam int KIND_WIDTH   = 6;
  localparam int ERR_WIDTH    = 2;

  // Stream widths: tdata carries offset, length, line, column
  localparam int DATA_RAW_W = 2 * OFFSET_WIDTH + 2 * LENGTH_WIDTH;
  localparam int DATA_W     = ((DATA_RAW_W + 7) / 8) * 8;
  localparam int USER_W     = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_OPS   = 13;
  localparam int OPIDX_W   = $clog2(NUM_OPS);
  localparam int NUM_SINGL = 8;
  localparam int NUM_KW    = 11;
  localparam int PREFIX_N  = 6;

  typedef logic [7:0]              byte_t;
  typedef logic [KIND_WIDTH-1:0]   kind_t;
  typedef logic [OFFSET_WIDTH-1:0] off_t;
  typedef logic [LENGTH_WIDTH-1:0] len_t;
  typedef logic [OPIDX_W-1:0]      opidx_t;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_NONE    = 2'd0,
    ERR_ILLEGAL = 2'd1,
    ERR_UNTERM  = 2'd2
  } err_e;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_WORD    = 6'b000010,
    MODE_OP      = 6'b000100,
    MODE_STRING  = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_ERROR   = 6'b100000
  } mode_e;

  localparam kind_t KIND_EOF    = 6'd0;
  localparam kind_t KIND_NUMBER = 6'd52;
  localparam kind_t KIND_STRING = 6'd53;
  localparam kind_t KIND_IDENT  = 6'd54;

  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_SLASH = 8'h2F;

  // Two-character operator table: lead char, base kind, follow chars
  localparam byte_t OP_CHAR [NUM_OPS] = '{
    "*", "/", "+", "-", "%", "<", ">", "&", "|", "^", ":", "=", "!"
  };
  localparam kind_t OP_BASE [NUM_OPS] = '{
    6'd25, 6'd27, 6'd29, 6'd32, 6'd35, 6'd18, 6'd21, 6'd37, 6'd40, 6'd50,
    6'd43, 6'd46, 6'd16
  };
  localparam byte_t OP_F1 [NUM_OPS] = '{
    "=", "=", "=", "=", "=", "=", "=", "=", "=", "=", ":", "=", "="
  };
  localparam byte_t OP_F2 [NUM_OPS] = '{
    CH_NUL, CH_NUL, "+", "-", CH_NUL, "<", ">", "&", "|", CH_NUL, CH_NUL,
    CH_NUL, CH_NUL
  };
  localparam opidx_t OP_IDX_SLASH = 4'd1;

  // Single-character punctuators
  localparam byte_t SG_CHAR [NUM_SINGL] = '{"(", ")", "{", "}", ",", ";", "[", "]"};
  localparam kind_t SG_KIND [NUM_SINGL] = '{
    6'd12, 6'd13, 6'd14, 6'd15, 6'd24, 6'd45, 6'd48, 6'd49
  };

  // Keywords, first byte in the low bits
  localparam logic [8*PREFIX_N-1:0] KW_TEXT [NUM_KW] = '{
    {24'd0, "tni"}, {8'd0, "taolf"}, "elbuod", {16'd0, "rahc"}, "gnirts",
    {32'd0, "fi"}, {16'd0, "esle"}, {32'd0, "nf"}, {24'd0, "rof"},
    {8'd0, "elihw"}, "nruter"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd2, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6
  };

  typedef struct packed {
    kind_t kind;
    err_e  err;
    off_t  off;
    len_t  len;
    off_t  line;
    len_t  col;
  } result_t;

  // One byte's worth of results: one or two
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } record_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic off_t sat_off(off_t v);
    return (v == '1) ? v : off_t'(v + 1'b1);
  endfunction

  function automatic len_t sat_len(len_t v);
    return (v == '1) ? v : len_t'(v + 1'b1);
  endfunction

endpackage

[hw/rtl/stk_front.sv]
// ----------------------------------------------------------------------------
// Source token scanner: front end
// Accepts source bytes, runs the scan state machine and pushes one record
// holding the one or two results that a byte produces.
// ----------------------------------------------------------------------------
module stk_front import stk_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  input  byte_t   s_tdata_i,
  output logic    s_tready_o,
  input  logic    room_i,
  output logic    push_o,
  output record_t rec_o
);

  mode_e                     mode_q, mode_d;
  opidx_t                    op_q, op_d;
  logic [8*PREFIX_N-1:0]     prefix_q, prefix_d;
  logic                      is_num_q, is_num_d;
  off_t                      tok_off_q, tok_off_d;
  off_t                      tok_line_q, tok_line_d;
  len_t                      tok_col_q, tok_col_d;
  len_t                      tok_len_q, tok_len_d;
  off_t                      off_q, off_d;
  off_t                      line_q, line_d;
  len_t                      col_q, col_d;

  logic    accept;
  byte_t   b;
  logic    b_digit, b_word, b_ws, b_term;
  logic    op_hit, sg_hit;
  opidx_t  op_idx;
  kind_t   sg_kind;

  logic    idle_emit, idle_restart, idle_start, idle_err;
  mode_e   idle_mode;
  result_t idle_res;

  logic    kw_hit;
  kind_t   kw_kind, word_kind;

  logic    pre_emit, use_idle, restart;
  result_t pre_res;

  assign accept     = s_tvalid_i && room_i;
  assign s_tready_o = room_i;
  assign b          = s_tdata_i;

  // Classify the byte
  assign b_digit = (b >= "0") && (b <= "9");
  assign b_word  = b_digit || ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
                   || (b == "_");
  assign b_ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL);
  assign b_term  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_NUL);

  always_comb begin
    op_hit  = 1'b0;
    op_idx  = '0;
    sg_hit  = 1'b0;
    sg_kind = KIND_EOF;
    for (int i = 0; i < NUM_OPS; i++) begin
      if (b == OP_CHAR[i]) begin
        op_hit = 1'b1;
        op_idx = opidx_t'(i);
      end
    end
    for (int i = 0; i < NUM_SINGL; i++) begin
      if (b == SG_CHAR[i]) begin
        sg_hit  = 1'b1;
        sg_kind = SG_KIND[i];
      end
    end
  end

  // Scan a byte between tokens
  always_comb begin
    idle_emit    = 1'b0;
    idle_restart = 1'b0;
    idle_start   = 1'b0;
    idle_err     = 1'b0;
    idle_mode    = MODE_IDLE;
    idle_res     = '{kind: KIND_EOF, err: ERR_NONE, off: off_q, len: '0,
                     line: line_q, col: col_q};
    priority if (b_ws) begin
      idle_mode = MODE_IDLE;
    end else if (b == CH_NUL) begin
      idle_emit    = 1'b1;
      idle_restart = 1'b1;
    end else if (op_hit) begin
      idle_start = 1'b1;
      idle_mode  = MODE_OP;
    end else if (sg_hit) begin
      idle_emit     = 1'b1;
      idle_res.kind = sg_kind;
      idle_res.len  = len_t'(1);
    end else if (b == CH_QUOTE) begin
      idle_start = 1'b1;
      idle_mode  = MODE_STRING;
    end else if (b_word) begin
      idle_start = 1'b1;
      idle_mode  = MODE_WORD;
    end else begin
      idle_emit    = 1'b1;
      idle_err     = 1'b1;
      idle_mode    = MODE_ERROR;
      idle_res.err = ERR_ILLEGAL;
      idle_res.len = len_t'(1);
    end
  end

  // Keyword match on the held prefix
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if ((tok_len_q == len_t'(KW_LEN[i])) && (prefix_q == KW_TEXT[i])) begin
        kw_hit  = 1'b1;
        kw_kind = kind_t'(i + 1);
      end
    end
    priority if (is_num_q)        word_kind = KIND_NUMBER;
    else if (!b_term || !kw_hit)  word_kind = KIND_IDENT;
    else                          word_kind = kw_kind;
  end

  // Next state for the current mode
  always_comb begin
    mode_d     = mode_q;
    op_d       = op_q;
    prefix_d   = prefix_q;
    is_num_d   = is_num_q;
    tok_off_d  = tok_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    off_d      = off_q;
    line_d     = line_q;
    col_d      = col_q;
    pre_emit   = 1'b0;
    use_idle   = 1'b0;
    restart    = 1'b0;
    pre_res    = '{kind: KIND_EOF, err: ERR_NONE, off: tok_off_q, len: tok_len_q,
                   line: tok_line_q, col: tok_col_q};

    unique case (mode_q)
      MODE_ERROR: begin
        restart = (b == CH_NUL);
      end
      MODE_COMMENT: begin
        use_idle = (b == CH_NL) || (b == CH_NUL);
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          pre_emit     = 1'b1;
          pre_res.kind = KIND_STRING;
          pre_res.len  = sat_len(tok_len_q);
          mode_d       = MODE_IDLE;
        end else if ((b == CH_NL) || (b == CH_NUL)) begin
          pre_emit    = 1'b1;
          pre_res.err = ERR_UNTERM;
          mode_d      = MODE_ERROR;
          restart     = (b == CH_NUL);
        end else begin
          tok_len_d = sat_len(tok_len_q);
        end
      end
      MODE_WORD: begin
        if (b_word) begin
          for (int i = 0; i < PREFIX_N; i++) begin
            if (tok_len_q == len_t'(i)) prefix_d[8*i +: 8] = b;
          end
          tok_len_d = sat_len(tok_len_q);
        end else begin
          pre_emit     = 1'b1;
          pre_res.kind = word_kind;
          use_idle     = 1'b1;
        end
      end
      MODE_OP: begin
        if ((op_q == OP_IDX_SLASH) && (b == CH_SLASH)) begin
          mode_d = MODE_COMMENT;
        end else if ((b != CH_NUL) && (b == OP_F1[op_q])) begin
          pre_emit     = 1'b1;
          pre_res.kind = kind_t'(OP_BASE[op_q] + 6'd1);
          pre_res.len  = len_t'(2);
          mode_d       = MODE_IDLE;
        end else if ((b != CH_NUL) && (b == OP_F2[op_q])) begin
          pre_emit     = 1'b1;
          pre_res.kind = kind_t'(OP_BASE[op_q] + 6'd2);
          pre_res.len  = len_t'(2);
          mode_d       = MODE_IDLE;
        end else begin
          pre_emit     = 1'b1;
          pre_res.kind = OP_BASE[op_q];
          pre_res.len  = len_t'(1);
          use_idle     = 1'b1;
        end
      end
      MODE_IDLE: begin
        use_idle = 1'b1;
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    // Apply the between-token scan
    if (use_idle) begin
      mode_d  = idle_err ? MODE_ERROR : (idle_start ? idle_mode : MODE_IDLE);
      restart = idle_restart;
      if (idle_start) begin
        tok_off_d  = off_q;
        tok_line_d = line_q;
        tok_col_d  = col_q;
        tok_len_d  = len_t'(1);
        op_d       = op_idx;
        if (idle_mode == MODE_WORD) begin
          prefix_d = {{(8*PREFIX_N-8){1'b0}}, b};
          is_num_d = b_digit;
        end
      end
    end

    // Restart the source or advance the position
    if (restart) begin
      mode_d     = MODE_IDLE;
      op_d       = '0;
      prefix_d   = '0;
      is_num_d   = 1'b0;
      tok_off_d  = '0;
      tok_line_d = off_t'(1);
      tok_col_d  = len_t'(1);
      tok_len_d  = '0;
      off_d      = '0;
      line_d     = off_t'(1);
      col_d      = len_t'(1);
    end else begin
      off_d = sat_off(off_q);
      if (b == CH_NL) begin
        line_d = sat_off(line_q);
        col_d  = len_t'(1);
      end else if (b != CH_NUL) begin
        col_d = sat_len(col_q);
      end
    end
  end

  // Build the record
  always_comb begin
    rec_o.two = pre_emit && use_idle && idle_emit;
    rec_o.r0  = pre_emit ? pre_res : idle_res;
    rec_o.r1  = idle_res;
    push_o    = accept && (pre_emit || (use_idle && idle_emit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      op_q       <= '0;
      prefix_q   <= '0;
      is_num_q   <= 1'b0;
      tok_off_q  <= '0;
      tok_line_q <= off_t'(1);
      tok_col_q  <= len_t'(1);
      tok_len_q  <= '0;
      off_q      <= '0;
      line_q     <= off_t'(1);
      col_q      <= len_t'(1);
    end else if (accept) begin
      mode_q     <= mode_d;
      op_q       <= op_d;
      prefix_q   <= prefix_d;
      is_num_q   <= is_num_d;
      tok_off_q  <= tok_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
      off_q      <= off_d;
      line_q     <= line_d;
      col_q      <= col_d;
    end
  end

endmodule

[hw/rtl/stk_queue.sv]
// ----------------------------------------------------------------------------
// Source token scanner: record queue
// Short FIFO of result records between the front end and the output side.
// ----------------------------------------------------------------------------
module stk_queue import stk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  record_t   push_rec_i,
  input  logic      pop_i,
  output record_t   head_o,
  output q_status_t status_o
);

  `include "source_token_scanner_top_defines.svh"

  record_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_q + 1'b1);
    end
    if (push_i && !pop_i)      cnt_d = QCNT_W'(cnt_q + 1'b1);
    else if (pop_i && !push_i) cnt_d = QCNT_W'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed records
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= push_rec_i;
  end

  `STK_ASSERT_IMP(a_push_not_full, push_i, !status_o.full, "push into full queue")
  `STK_ASSERT_IMP(a_pop_not_empty, pop_i, !status_o.empty, "pop from empty queue")
  `STK_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

[hw/rtl/stk_back.sv]
// ----------------------------------------------------------------------------
// Source token scanner: output side
// Pops records and presents their results one beat at a time through an
// output register, the second result of a pair held aside.
// ----------------------------------------------------------------------------
module stk_back import stk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  record_t           head_i,
  input  q_status_t         status_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,
  output logic [USER_W-1:0] m_tuser_o,
  output logic              m_tlast_o
);

  `include "source_token_scanner_top_defines.svh"

  logic    valid_q, valid_d;
  logic    pend_q, pend_d;
  logic    last_q, last_d;
  result_t res_q, res_d;
  result_t second_q, second_d;
  logic    out_free;

  assign out_free = !valid_q || m_tready_i;

  // Load the next beat when the output register frees up
  always_comb begin
    valid_d  = valid_q;
    pend_d   = pend_q;
    last_d   = last_q;
    res_d    = res_q;
    second_d = second_q;
    pop_o    = 1'b0;
    if (out_free) begin
      priority if (pend_q) begin
        valid_d = 1'b1;
        res_d   = second_q;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!status_i.empty) begin
        pop_o    = 1'b1;
        valid_d  = 1'b1;
        res_d    = head_i.r0;
        last_d   = !head_i.two;
        pend_d   = head_i.two;
        second_d = head_i.r1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    second_q <= second_d;
  end

  // Pack the beat
  assign m_tvalid_o = valid_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = DATA_W'({res_q.col, res_q.line, res_q.len, res_q.off});
  assign m_tuser_o  = USER_W'({res_q.err, res_q.kind});

  `STK_ASSERT_IMP(a_pend_shown, pend_q, valid_q, "second result pending without a shown beat")
  `STK_ASSERT_IMP(a_pend_not_last, pend_q, !last_q, "first of a pair marked last")
  `STK_ASSERT_NXT(a_single_last, pop_o && !head_i.two, last_q,
                  "single result not marked last")

endmodule

[hw/rtl/source_token_scanner_top.sv]
// ----------------------------------------------------------------------------
// Source token scanner, top level
// Streams source bytes in and tokens out, with a front scanner and an
// output side decoupled by a short record queue.
//
//   Group    Dir  Payload                                    Beat
//   s_axis   in   tdata[7:0] source byte                     one byte
//   m_axis   out  tdata offset/length/line/column, tuser     one token
//                 kind/error code, tlast last of the byte
//
// One source byte is taken each cycle while the queue has room; scanning
// and keyword matching are done in the cycle of acceptance.
// The output side sends one token a cycle while the sink is ready; a byte
// yielding two tokens sends two beats, absorbed by the four-record queue.
// Input stalls only when the queue is full; output stalls hold the beat.
// Reset takes effect at once; no clearing pass follows it.
// ----------------------------------------------------------------------------
module source_token_scanner_top import stk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] source_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // start_offset, token_length,
                                            // start_line, start_column
  output logic [USER_W-1:0] m_axis_tuser,   // token_kind, error_code
  output logic              m_axis_tlast    // last_in_run
);

  logic      push, pop;
  record_t   push_rec, head_rec;
  q_status_t q_status;

  stk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tready_o (s_axis_tready),
    .room_i     (!q_status.full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  stk_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head_rec),
    .status_o   (q_status)
  );

  stk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_rec),
    .status_i   (q_status),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
